### design/gcode_line_parser_assert.svh
// Assertion macros used by the parser top level.
`ifndef GCODE_LINE_PARSER_ASSERT_SVH
`define GCODE_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GCLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gclp_pkg.sv
// Types, constants and helpers of the G-code line parser.
package gclp_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         command_letter;
    logic [15:0]        command_number;
    logic [6:0]         present_mask;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic signed [31:0] e_value;
    logic signed [31:0] f_value;
    logic signed [31:0] s_value;
    logic signed [31:0] p_value;
  } out_item_t;

  // Classified character handed from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       last;
    logic       is_ws;
    logic       is_digit;
    logic [3:0] digit;
  } cls_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_CMDNUM,
    PH_GAP,
    PH_VSTART,
    PH_VRUN,
    PH_COMMENT
  } phase_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BLANK   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_CASE   = 8'h20;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_P      = 8'h50;

  // Powers of ten for integer and fraction digit weights.
  function automatic logic [23:0] pow10(input logic [2:0] e);
    logic [23:0] r;
    unique case (e)
      3'd0: r = 24'd1;
      3'd1: r = 24'd10;
      3'd2: r = 24'd100;
      3'd3: r = 24'd1000;
      3'd4: r = 24'd10000;
      3'd5: r = 24'd100000;
      3'd6: r = 24'd1000000;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  // One-hot parameter slot: bit0 X .. bit6 P.
  function automatic logic [6:0] slot_mask(input logic [7:0] c);
    logic [6:0] m;
    m = 7'd0;
    if (c == CH_X) m[0] = 1'b1;
    if (c == CH_Y) m[1] = 1'b1;
    if (c == CH_Z) m[2] = 1'b1;
    if (c == CH_E) m[3] = 1'b1;
    if (c == CH_F) m[4] = 1'b1;
    if (c == CH_S) m[5] = 1'b1;
    if (c == CH_P) m[6] = 1'b1;
    return m;
  endfunction

endpackage

### design/gcode_line_parser.sv
// G-code line parser top level: front classifier, parser back end, result queue.
// Characters of one line enter one per cycle through push/full while full is low;
// the item marked last yields one result transaction describing the whole line,
// read through empty/pop. The block sustains one character per clock while the
// result queue has room: the back end takes each character from the front queue
// in one pass through its compare and multiply-by-ten accumulate, and a line's
// result enters the result queue as its last item is taken. Only the item marked
// last waits on a full result queue; other characters never stall the parser.
// Parameter values come out in thousandths (10^-FRACTION_DIGITS), truncated,
// with magnitude saturating at 2^(VALUE_BITS-1)-1.
`include "gcode_line_parser_assert.svh"

module gcode_line_parser #(
  parameter int VALUE_BITS      = 32,
  parameter int FRACTION_DIGITS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  gclp_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output gclp_pkg::out_item_t result
);

  logic                fq_empty;
  logic                take;
  gclp_pkg::cls_t      head;
  logic                res_full;
  logic                res_push;
  gclp_pkg::out_item_t res;

  gclp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (fq_empty),
    .take  (take),
    .head  (head)
  );

  gclp_back #(
    .VALUE_BITS      (VALUE_BITS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (!fq_empty),
    .head     (head),
    .res_full (res_full),
    .take     (take),
    .res_push (res_push),
    .res      (res)
  );

  gclp_result_q u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (res),
    .full    (res_full),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  `GCLP_ASSERT_IMP(a_no_drop, res_push, !res_full, "result written into full queue")
  `GCLP_ASSERT_IMP(a_take_valid, take, !fq_empty, "parser took from empty queue")
  `GCLP_ASSERT_IMP(a_clean_status, res_push && res.status != gclp_pkg::ST_OK,
                   res.present_mask == 7'd0 && res.command_letter == 8'd0,
                   "non-command status carries fields")
  `GCLP_ASSERT_NXT(a_result_lands, res_push, !empty, "result transaction lost")

endmodule

### design/gclp_front.sv
// Front part: classifies incoming characters into a two-entry queue.
module gclp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  gclp_pkg::in_item_t item,
  output logic               empty,
  input  logic               take,
  output gclp_pkg::cls_t     head
);

  gclp_pkg::cls_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  gclp_pkg::cls_t cls;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    cls.ch_valid = item.ch_valid;
    cls.last     = item.last;
    if (item.ch >= gclp_pkg::CH_LOW_A && item.ch <= gclp_pkg::CH_LOW_Z) begin
      cls.ch = item.ch - gclp_pkg::CH_CASE;
    end else begin
      cls.ch = item.ch;
    end
    cls.is_ws = (cls.ch == gclp_pkg::CH_SPACE) ||
                (cls.ch >= gclp_pkg::CH_TAB && cls.ch <= gclp_pkg::CH_CR);
    cls.is_digit = (cls.ch >= gclp_pkg::CH_ZERO) && (cls.ch <= gclp_pkg::CH_NINE);
    cls.digit    = 4'(cls.ch - gclp_pkg::CH_ZERO);
  end

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = take && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### design/gclp_back.sv
// Back part: parse state machine, number accumulation and result build.
module gclp_back #(
  parameter int VALUE_BITS      = 32,
  parameter int FRACTION_DIGITS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  gclp_pkg::cls_t      head,
  input  logic                res_full,
  output logic                take,
  output logic                res_push,
  output gclp_pkg::out_item_t res
);

  localparam int W = ((VALUE_BITS > 28) ? VALUE_BITS : 28) + 4;
  localparam logic [W-1:0] MAG_MAX = ({{(W-1){1'b0}}, 1'b1} << (VALUE_BITS - 1)) - 1'b1;
  localparam logic [2:0] FD = 3'(FRACTION_DIGITS);
  localparam logic [23:0] INT_WEIGHT = gclp_pkg::pow10(3'(FRACTION_DIGITS));

  gclp_pkg::phase_t   phase, phase_char, phase_next;
  logic               seen_nonblank, seen_nonblank_next;
  logic               seen_content, seen_content_next;
  logic [7:0]         letter, letter_next;
  logic [15:0]        number, number_next;
  logic [7:0]         param_letter, param_letter_next;
  logic [W-1:0]       accum, accum_next;
  logic               sign, sign_next;
  logic               dot, dot_next;
  logic               stop, stop_next;
  logic [2:0]         frac, frac_next;
  logic signed [31:0] values [7];
  logic signed [31:0] values_next [7];
  logic [6:0]         present, present_next;

  logic [7:0]  c;
  logic        run_ch;
  logic        is_sp_letter;
  logic [19:0] num_mac;
  logic [27:0] dig_term;
  logic [W-1:0] acc_sum;
  logic [6:0]  cm;
  logic [31:0] cv;

  assign take     = avail && (!head.last || !res_full);
  assign res_push = take && head.last;
  assign c        = head.ch;
  assign run_ch   = head.is_digit || (c == gclp_pkg::CH_DOT) || (c == gclp_pkg::CH_MINUS);
  assign is_sp_letter = (c != gclp_pkg::CH_SEMI) && (c != gclp_pkg::CH_SPACE);

  function automatic gclp_pkg::phase_t start_phase(input logic [7:0] ch);
    gclp_pkg::phase_t p;
    if (ch == gclp_pkg::CH_SEMI) p = gclp_pkg::PH_COMMENT;
    else if (ch == gclp_pkg::CH_SPACE) p = gclp_pkg::PH_GAP;
    else p = gclp_pkg::PH_VSTART;
    return p;
  endfunction

  function automatic logic [31:0] signed_value(input logic [W-1:0] mag, input logic neg);
    logic [W-1:0] v;
    v = neg ? ({W{1'b0}} - mag) : mag;
    return v[31:0];
  endfunction

  // Next state of the parse phase.
  always_comb begin
    phase_char = phase;
    if (take && head.ch_valid) begin
      unique case (phase)
        gclp_pkg::PH_LEAD: begin
          if (!head.is_ws) begin
            phase_char = (c == gclp_pkg::CH_SEMI) ? gclp_pkg::PH_COMMENT
                                                  : gclp_pkg::PH_CMDNUM;
          end
        end
        gclp_pkg::PH_CMDNUM: begin
          if (!head.is_digit && c != gclp_pkg::CH_DOT) phase_char = start_phase(c);
        end
        gclp_pkg::PH_GAP: phase_char = start_phase(c);
        gclp_pkg::PH_VSTART, gclp_pkg::PH_VRUN: begin
          phase_char = run_ch ? gclp_pkg::PH_VRUN : start_phase(c);
        end
        gclp_pkg::PH_COMMENT: phase_char = phase;
        default: phase_char = gclp_pkg::PH_LEAD;
      endcase
    end
    phase_next = res_push ? gclp_pkg::PH_LEAD : phase_char;
  end

  // Datapath and result.
  always_comb begin
    seen_nonblank_next = seen_nonblank;
    seen_content_next  = seen_content;
    letter_next        = letter;
    number_next        = number;
    param_letter_next  = param_letter;
    accum_next         = accum;
    sign_next          = sign;
    dot_next           = dot;
    stop_next          = stop;
    frac_next          = frac;
    values_next        = values;
    present_next       = present;
    num_mac  = 20'(number) * 20'd10 + 20'(head.digit);
    acc_sum  = {W{1'b0}};
    dig_term = 28'd0;
    cm = gclp_pkg::slot_mask(param_letter);
    cv = signed_value(accum, sign);
    res = '0;

    if (take && head.ch_valid) begin
      unique case (phase)
        gclp_pkg::PH_LEAD: begin
          if (!head.is_ws) begin
            seen_nonblank_next = 1'b1;
            if (c != gclp_pkg::CH_SEMI) begin
              seen_content_next = 1'b1;
              letter_next = c;
              number_next = 16'd0;
              sign_next = 1'b0;
              dot_next  = 1'b0;
              stop_next = 1'b0;
              frac_next = 3'd0;
            end
          end
        end
        gclp_pkg::PH_CMDNUM: begin
          if (head.is_digit) begin
            if (!stop) number_next = (num_mac > 20'd65535) ? 16'hFFFF : num_mac[15:0];
          end else if (c == gclp_pkg::CH_DOT) begin
            stop_next = 1'b1;
          end else if (is_sp_letter) begin
            param_letter_next = c;
            accum_next = {W{1'b0}};
            sign_next = 1'b0;
            dot_next  = 1'b0;
            stop_next = 1'b0;
            frac_next = 3'd0;
          end
        end
        gclp_pkg::PH_GAP: begin
          if (is_sp_letter) begin
            param_letter_next = c;
            accum_next = {W{1'b0}};
            sign_next = 1'b0;
            dot_next  = 1'b0;
            stop_next = 1'b0;
            frac_next = 3'd0;
          end
        end
        gclp_pkg::PH_VSTART, gclp_pkg::PH_VRUN: begin
          if (run_ch) begin
            if (c == gclp_pkg::CH_MINUS) begin
              if (phase == gclp_pkg::PH_VSTART) sign_next = 1'b1;
              else stop_next = 1'b1;
            end else if (c == gclp_pkg::CH_DOT) begin
              if (dot) stop_next = 1'b1;
              else if (!stop) dot_next = 1'b1;
            end else if (!stop) begin
              // Accumulate directly in output units; saturation is monotonic.
              if (!dot) begin
                dig_term = 28'(head.digit) * 28'(INT_WEIGHT);
                acc_sum = (accum << 3) + (accum << 1) + W'(dig_term);
                accum_next = (acc_sum > MAG_MAX) ? MAG_MAX : acc_sum;
              end else if (frac < FD) begin
                dig_term = 28'(head.digit) * 28'(gclp_pkg::pow10(FD - 3'd1 - frac));
                acc_sum = accum + W'(dig_term);
                accum_next = (acc_sum > MAG_MAX) ? MAG_MAX : acc_sum;
                frac_next = frac + 3'd1;
              end
            end
          end else begin
            if (phase == gclp_pkg::PH_VRUN) begin
              for (int k = 0; k < 7; k++) begin
                if (cm[k]) values_next[k] = cv;
              end
              present_next = present | cm;
            end
            if (is_sp_letter) begin
              param_letter_next = c;
              accum_next = {W{1'b0}};
              sign_next = 1'b0;
              dot_next  = 1'b0;
              stop_next = 1'b0;
              frac_next = 3'd0;
            end
          end
        end
        gclp_pkg::PH_COMMENT: begin
          seen_nonblank_next = seen_nonblank;
        end
        default: begin
          seen_nonblank_next = seen_nonblank;
        end
      endcase
    end

    if (res_push) begin
      // Close an open run before building the transaction.
      if (phase_char == gclp_pkg::PH_VRUN) begin
        cm = gclp_pkg::slot_mask(param_letter_next);
        cv = signed_value(accum_next, sign_next);
        for (int k = 0; k < 7; k++) begin
          if (cm[k]) values_next[k] = cv;
        end
        present_next = present_next | cm;
      end
      if (!seen_nonblank_next) begin
        res.status = gclp_pkg::ST_BLANK;
      end else if (!seen_content_next) begin
        res.status = gclp_pkg::ST_INVALID;
      end else begin
        res.status         = gclp_pkg::ST_OK;
        res.command_letter = letter_next;
        res.command_number = number_next;
        res.present_mask   = present_next;
        res.x_value        = values_next[0];
        res.y_value        = values_next[1];
        res.z_value        = values_next[2];
        res.e_value        = values_next[3];
        res.f_value        = values_next[4];
        res.s_value        = values_next[5];
        res.p_value        = values_next[6];
      end
      seen_nonblank_next = 1'b0;
      seen_content_next  = 1'b0;
      letter_next        = 8'd0;
      number_next        = 16'd0;
      param_letter_next  = 8'd0;
      accum_next         = {W{1'b0}};
      sign_next          = 1'b0;
      dot_next           = 1'b0;
      stop_next          = 1'b0;
      frac_next          = 3'd0;
      for (int k = 0; k < 7; k++) values_next[k] = 32'sd0;
      present_next       = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= gclp_pkg::PH_LEAD;
      seen_nonblank <= 1'b0;
      seen_content  <= 1'b0;
      letter        <= 8'd0;
      number        <= 16'd0;
      param_letter  <= 8'd0;
      accum         <= {W{1'b0}};
      sign          <= 1'b0;
      dot           <= 1'b0;
      stop          <= 1'b0;
      frac          <= 3'd0;
      for (int k = 0; k < 7; k++) values[k] <= 32'sd0;
      present       <= 7'd0;
    end else begin
      phase         <= phase_next;
      seen_nonblank <= seen_nonblank_next;
      seen_content  <= seen_content_next;
      letter        <= letter_next;
      number        <= number_next;
      param_letter  <= param_letter_next;
      accum         <= accum_next;
      sign          <= sign_next;
      dot           <= dot_next;
      stop          <= stop_next;
      frac          <= frac_next;
      values        <= values_next;
      present       <= present_next;
    end
  end

endmodule

### design/gclp_result_q.sv
// Two-entry result queue in front of the result ports.
module gclp_result_q (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  gclp_pkg::out_item_t wr_data,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output gclp_pkg::out_item_t result
);

  gclp_pkg::out_item_t mem [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                do_wr;
  logic                do_pop;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign do_wr  = wr && !full;
  assign do_pop = pop && !empty;
  assign result = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr)  wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_pop);
    end
  end

endmodule
